@@ sv/uer_pkg.sv @@
// shared types, constants and helpers of the ultrasonic echo ranger
`default_nettype none

package uer_pkg;

    // counter geometry
    localparam int CNT_BITS = 16;
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << CNT_BITS) - 64'd1);

    // speed of sound as an exact ratio, halved for the round trip
    localparam int SPEED_NUM = 343;
    localparam int SPEED_DEN = 20000;
    localparam int REM_W     = 15;
    localparam int DIST_W    = 11;

    // register indexes
    localparam logic [1:0] REG_TRIG_LOW  = 2'd0;
    localparam logic [1:0] REG_TRIG_HIGH = 2'd1;
    localparam logic [1:0] REG_RISE_TMO  = 2'd2;
    localparam logic [1:0] REG_ECHO_TMO  = 2'd3;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_TLOW  = 5'b00010,
        PH_THIGH = 5'b00100,
        PH_RISE  = 5'b01000,
        PH_ECHO  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0]  trig_low;
        logic [7:0]  trig_high;
        logic [15:0] rise_tmo;
        logic [15:0] echo_tmo;
    } t_cfg;

    typedef struct packed {
        t_phase              phase;
        logic [CNT_BITS-1:0] cnt;
        logic [DIST_W-1:0]   quo;
        logic [REM_W-1:0]    rem;
        logic [DIST_W-1:0]   last;
    } t_state;

    typedef struct packed {
        logic              trig;
        logic              busy;
        logic              done;
        logic              tmo;
        logic [DIST_W-1:0] distance;
    } t_result;

    // timeout of zero acts as one, anything past the counter range is clamped
    function automatic logic [31:0] clamp_limit(input logic [15:0] t);
        logic [31:0] v;
        v = (t == 16'd0) ? 32'd1 : 32'(t);
        if (v > CNT_MAX) begin
            v = CNT_MAX;
        end
        return v;
    endfunction

    function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] c);
        return (c == {CNT_BITS{1'b1}}) ? c : c + CNT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

@@ sv/ultrasonic_echo_ranger.sv @@
// top level of the ultrasonic echo ranger
//
// one input transaction is one microsecond tick: tdata[0] requests a new
// measurement, tdata[1] is the sampled echo pin level.  every tick gives
// exactly one output transaction with the trigger level to drive, busy,
// done, the timeout flag and the last distance in centimetres.
// a measurement drives the trigger low, then high, waits for the echo to
// rise and counts the echo-high ticks; distance = ticks * 343 / 20000,
// kept as a running quotient and remainder so no divider is needed.
// the result of a tick sits in the output register on the cycle after
// the tick is accepted.  throughput is one tick per cycle while the
// receiver takes results; the only loop is the phase and counter
// update in uer_step.  when the receiver stalls, the result is held and
// a new tick is taken only in the cycle the held result leaves.
// reset (synchronous, active low) returns to idle with zero distance and
// loads the registers with 2, 10, 65535, 65535.  the user writes registers
// via the plain write port only while idle; the block does not enforce it.
`default_nettype none

module ultrasonic_echo_ranger (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input: [0] command, [1] echo_level, [7:2] zero
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,
    // result: [0] trigger_level, [1] busy_res, [2] done_res, [3] timed_out,
    // [14:4] distance_cm, [15] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    // register writes
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    uer_pkg::t_cfg    r_cfg;
    uer_pkg::t_state  r_state;
    uer_pkg::t_state  n_state;
    uer_pkg::t_result n_result;
    logic             r_m_valid;
    logic [15:0]      r_m_data;
    logic             s_accept;

    // output register frees up when empty or being drained
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    uer_step u_step (
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .i_command    (i_s_tdata[0]),
        .i_echo_level (i_s_tdata[1]),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig_low  <= 8'd2;
            r_cfg.trig_high <= 8'd10;
            r_cfg.rise_tmo  <= 16'hFFFF;
            r_cfg.echo_tmo  <= 16'hFFFF;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                uer_pkg::REG_TRIG_LOW:  r_cfg.trig_low  <= i_cfg_wdata[7:0];
                uer_pkg::REG_TRIG_HIGH: r_cfg.trig_high <= i_cfg_wdata[7:0];
                uer_pkg::REG_RISE_TMO:  r_cfg.rise_tmo  <= i_cfg_wdata;
                uer_pkg::REG_ECHO_TMO:  r_cfg.echo_tmo  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // measurement state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= uer_pkg::PH_IDLE;
            r_state.cnt   <= '0;
            r_state.quo   <= '0;
            r_state.rem   <= '0;
            r_state.last  <= '0;
        end else if (s_accept) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_accept) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= {1'b0, n_result.distance, n_result.tmo, n_result.done,
                         n_result.busy, n_result.trig};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

@@ sv/uer_step.sv @@
// next-state and result logic for one tick
`default_nettype none

module uer_step (
    input  uer_pkg::t_cfg    i_cfg,
    input  uer_pkg::t_state  i_state,
    input  logic             i_command,
    input  logic             i_echo_level,
    output uer_pkg::t_state  o_state,
    output uer_pkg::t_result o_result
);

    always_comb begin
        uer_pkg::t_state s;
        logic            stop;
        logic            trig;
        logic            busy;
        logic            done;
        logic            tmo;
        logic [uer_pkg::REM_W:0] rsum;

        s    = i_state;
        stop = 1'b0;
        trig = 1'b0;
        busy = 1'b0;
        done = 1'b0;
        tmo  = 1'b0;
        rsum = '0;

        if (s.phase == uer_pkg::PH_IDLE && i_command) begin
            s.phase = uer_pkg::PH_TLOW;
            s.cnt   = '0;
        end

        // trigger low lead-in
        if (s.phase == uer_pkg::PH_TLOW) begin
            if (32'(s.cnt) < 32'(i_cfg.trig_low)) begin
                s.cnt = uer_pkg::count_up(s.cnt);
                busy  = 1'b1;
                stop  = 1'b1;
            end else begin
                s.phase = uer_pkg::PH_THIGH;
                s.cnt   = '0;
            end
        end

        // trigger pulse
        if (!stop && s.phase == uer_pkg::PH_THIGH) begin
            if (32'(s.cnt) < 32'(i_cfg.trig_high)) begin
                s.cnt = uer_pkg::count_up(s.cnt);
                trig  = 1'b1;
                busy  = 1'b1;
                stop  = 1'b1;
            end else begin
                s.phase = uer_pkg::PH_RISE;
                s.cnt   = '0;
            end
        end

        // wait for echo rising
        if (!stop && s.phase == uer_pkg::PH_RISE) begin
            if (!i_echo_level) begin
                s.cnt = uer_pkg::count_up(s.cnt);
                if (32'(s.cnt) >= uer_pkg::clamp_limit(i_cfg.rise_tmo)) begin
                    done    = 1'b1;
                    tmo     = 1'b1;
                    s.last  = '0;
                    s.phase = uer_pkg::PH_IDLE;
                    s.cnt   = '0;
                end else begin
                    busy = 1'b1;
                end
                stop = 1'b1;
            end else begin
                s.phase = uer_pkg::PH_ECHO;
                s.cnt   = '0;
                s.quo   = '0;
                s.rem   = '0;
            end
        end

        // echo high: distance kept as running quotient and remainder
        if (!stop && s.phase == uer_pkg::PH_ECHO) begin
            if (i_echo_level) begin
                s.cnt = uer_pkg::count_up(s.cnt);
                rsum  = {1'b0, s.rem} + (uer_pkg::REM_W+1)'(uer_pkg::SPEED_NUM);
                if (rsum >= (uer_pkg::REM_W+1)'(uer_pkg::SPEED_DEN)) begin
                    s.rem = uer_pkg::REM_W'(rsum - (uer_pkg::REM_W+1)'(uer_pkg::SPEED_DEN));
                    s.quo = s.quo + uer_pkg::DIST_W'(1);
                end else begin
                    s.rem = uer_pkg::REM_W'(rsum);
                end
                if (32'(s.cnt) >= uer_pkg::clamp_limit(i_cfg.echo_tmo)) begin
                    done    = 1'b1;
                    tmo     = 1'b1;
                    s.last  = '0;
                    s.phase = uer_pkg::PH_IDLE;
                    s.cnt   = '0;
                end else begin
                    busy = 1'b1;
                end
            end else begin
                s.last  = s.quo;
                done    = 1'b1;
                s.phase = uer_pkg::PH_IDLE;
                s.cnt   = '0;
            end
        end

        o_state           = s;
        o_result.trig     = trig;
        o_result.busy     = busy;
        o_result.done     = done;
        o_result.tmo      = tmo;
        o_result.distance = s.last;
    end

endmodule

`default_nettype wire

@@ sv/uer_checker.sv @@
// port-level checks of the ultrasonic echo ranger and their binding
`default_nettype none

module uer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata
);

    // held result stays put while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result changed under stall");

    // a timeout always reports zero distance
    a_tmo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[3] |-> i_m_tdata[14:4] == 11'd0 && i_m_tdata[2])
        else $error("timeout without done or with nonzero distance");

    // the finishing tick is neither busy nor triggering
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[2] |-> !i_m_tdata[1] && !i_m_tdata[0])
        else $error("done tick still busy or triggering");

    // trigger only ever high inside a measurement
    a_trig_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[0] |-> i_m_tdata[1])
        else $error("trigger high while not busy");

    // distance only changes on a done result
    a_dist_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && $past(i_m_tvalid) && !i_m_tdata[2]
        && $past(i_rst_n) |-> i_m_tdata[14:4] == $past(i_m_tdata[14:4]))
        else $error("distance changed without done");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

`default_nettype wire

@@ tb/ultrasonic_echo_ranger_test.sv @@
// self-checking testbench of the ultrasonic echo ranger with its own tick-level predictor
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_test;

    // directed stimulus row: one tick, with a hand-typed result where it is obvious
    typedef struct packed {
        logic             start;
        logic             echo;
        logic             pinned;
        uer_pkg::t_result want;
    } t_row;

    // results that can be read off at a glance
    localparam uer_pkg::t_result IDLE_RES  = '{1'b0, 1'b0, 1'b0, 1'b0, 11'd0};
    localparam uer_pkg::t_result PULSE_RES = '{1'b1, 1'b1, 1'b0, 1'b0, 11'd0};
    localparam uer_pkg::t_result TMO_RES   = '{1'b0, 1'b0, 1'b1, 1'b1, 11'd0};

    // directed ticks, run with trigger low 0, trigger high 1, rise timeout 0, echo timeout 3
    localparam t_row DIR_STEPS [13] = '{
        '{1'b0, 1'b0, 1'b1, IDLE_RES},   // idle straight after reset
        '{1'b0, 1'b1, 1'b1, IDLE_RES},   // echo high while idle changes nothing
        '{1'b1, 1'b0, 1'b1, PULSE_RES},  // start, empty low phase skipped at once
        '{1'b1, 1'b1, 1'b0, IDLE_RES},   // start while busy, echo seen at once
        '{1'b0, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, 1'b0, 1'b0, IDLE_RES},   // echo falls after two ticks, distance rounds to zero
        '{1'b1, 1'b0, 1'b1, PULSE_RES},
        '{1'b0, 1'b0, 1'b1, TMO_RES},    // rise timeout of zero behaves as one
        '{1'b1, 1'b1, 1'b1, PULSE_RES},
        '{1'b0, 1'b1, 1'b0, IDLE_RES},
        '{1'b0, 1'b1, 1'b0, IDLE_RES},
        '{1'b1, 1'b1, 1'b1, TMO_RES},    // echo timeout, start on the done tick ignored
        '{1'b0, 1'b0, 1'b1, IDLE_RES}    // so the block is idle again here
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'd0;      // [0] command, [1] echo_level, [7:2] zero
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;             // [0] trigger, [1] busy, [2] done, [3] timed out,
                                        // [14:4] distance_cm, [15] zero
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_addr = uer_pkg::REG_TRIG_LOW;
    logic [15:0] i_cfg_wdata = 16'd0;

    // predictor copy of the registers, reset values
    logic [7:0]  cfg_trig_low = 8'd2;
    logic [7:0]  cfg_trig_high = 8'd10;
    logic [15:0] cfg_rise_tmo = 16'hFFFF;
    logic [15:0] cfg_echo_tmo = 16'hFFFF;

    // predictor copy of the ranging state
    uer_pkg::t_phase            rng_phase = uer_pkg::PH_IDLE;
    int unsigned                rng_count = 0;
    logic [uer_pkg::DIST_W-1:0] rng_dist = '0;

    uer_pkg::t_result pending_readings[$];
    int      mismatches = 0;
    int      ticks_sent = 0;

    // per side (0 tick source, 1 result sink): length of the current stretch and
    // whether it runs without any idling
    int span_left[2] = '{0, 0};
    bit quiet[2] = '{1'b0, 1'b0};

    ultrasonic_echo_ranger u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // a timeout of zero counts as one, and nothing beyond the counter's reach
    function automatic int unsigned eff_limit(input logic [15:0] t);
        int unsigned lim;
        lim = (t == 16'd0) ? 1 : int'(t);
        if (lim > uer_pkg::CNT_MAX) begin
            lim = uer_pkg::CNT_MAX;
        end
        return lim;
    endfunction

    // counter sticks at its top value
    function automatic int unsigned sat_inc(input int unsigned c);
        return (c < uer_pkg::CNT_MAX) ? c + 1 : c;
    endfunction

    // advances the ranging state by one tick and returns what the block should report
    function automatic uer_pkg::t_result ranger_step(input logic start, input logic echo);
        uer_pkg::t_result r;
        logic    settled;
        logic    expired;
        r = '0;
        settled = 1'b0;
        expired = 1'b0;
        if (rng_phase == uer_pkg::PH_IDLE && start) begin
            rng_phase = uer_pkg::PH_TLOW;
            rng_count = 0;
        end
        // trigger low phase, falls through at once when its length is used up
        if (rng_phase == uer_pkg::PH_TLOW) begin
            if (rng_count < cfg_trig_low) begin
                rng_count = sat_inc(rng_count);
                r.busy = 1'b1;
                settled = 1'b1;
            end else begin
                rng_phase = uer_pkg::PH_THIGH;
                rng_count = 0;
            end
        end
        // trigger pulse
        if (!settled && rng_phase == uer_pkg::PH_THIGH) begin
            if (rng_count < cfg_trig_high) begin
                rng_count = sat_inc(rng_count);
                r.trig = 1'b1;
                r.busy = 1'b1;
                settled = 1'b1;
            end else begin
                rng_phase = uer_pkg::PH_RISE;
                rng_count = 0;
            end
        end
        // waiting for the echo to rise, each low sample counts towards the timeout
        if (!settled && rng_phase == uer_pkg::PH_RISE) begin
            if (!echo) begin
                rng_count = sat_inc(rng_count);
                expired = (rng_count >= eff_limit(cfg_rise_tmo));
                r.busy = !expired;
                settled = 1'b1;
            end else begin
                rng_phase = uer_pkg::PH_ECHO;
                rng_count = 0;
            end
        end
        // echo high: count it, or convert the count when it falls
        if (!settled && rng_phase == uer_pkg::PH_ECHO) begin
            if (echo) begin
                rng_count = sat_inc(rng_count);
                expired = (rng_count >= eff_limit(cfg_echo_tmo));
                r.busy = !expired;
            end else begin
                rng_dist = uer_pkg::DIST_W'((rng_count * uer_pkg::SPEED_NUM)
                                            / uer_pkg::SPEED_DEN);
                r.done = 1'b1;
                rng_phase = uer_pkg::PH_IDLE;
                rng_count = 0;
            end
        end
        if (expired) begin
            r.done = 1'b1;
            r.tmo = 1'b1;
            rng_dist = '0;
            rng_phase = uer_pkg::PH_IDLE;
            rng_count = 0;
        end
        r.distance = rng_dist;
        return r;
    endfunction

    // idle cycles before the next transaction on one side, in stretches that
    // are either calm or drawn at random
    function automatic int idle_cycles(input int side);
        if (span_left[side] == 0) begin
            span_left[side] = $urandom_range(16, 64);
            quiet[side] = ($urandom_range(0, 3) == 0);
        end
        span_left[side]--;
        return quiet[side] ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic logic stray_start();
        return ($urandom_range(0, 7) == 0);
    endfunction

    function automatic logic [15:0] pick_timeout(input int mid_top);
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 8));
            1: return 16'($urandom_range(9, mid_top));
            2: return 16'($urandom_range(mid_top + 1, 65535));
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic void field_check(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // one tick transaction; valid stays high when the next tick follows with no gap
    task automatic send_tick(input logic start, input logic echo,
                             input logic pinned, input uer_pkg::t_result pinned_res);
        int      gap;
        uer_pkg::t_result r;
        gap = idle_cycles(0);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {6'd0, echo, start};
        do @(posedge i_clk); while (!o_s_tready);
        r = ranger_step(start, echo);
        pending_readings.push_back(pinned ? pinned_res : r);
        ticks_sent++;
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [7:0] low, input logic [7:0] high,
                              input logic [15:0] rise, input logic [15:0] echo_max);
        put_reg(uer_pkg::REG_TRIG_LOW, {8'd0, low});
        put_reg(uer_pkg::REG_TRIG_HIGH, {8'd0, high});
        put_reg(uer_pkg::REG_RISE_TMO, rise);
        put_reg(uer_pkg::REG_ECHO_TMO, echo_max);
        i_cfg_wr_en <= 1'b0;
        cfg_trig_low = low;
        cfg_trig_high = high;
        cfg_rise_tmo = rise;
        cfg_echo_tmo = echo_max;
    endtask

    // a well-formed measurement: start, trigger, some low samples, an echo pulse
    task automatic run_measurement();
        int unsigned rise_lim;
        int unsigned echo_lim;
        int          rise_wait;
        int          echo_len;
        int          n;
        rise_lim = eff_limit(cfg_rise_tmo);
        echo_lim = eff_limit(cfg_echo_tmo);
        // reach the timeouts only when they are short enough to be worth it
        rise_wait = (rise_lim <= 64) ? $urandom_range(0, rise_lim + 2) : $urandom_range(0, 30);
        if (echo_lim <= 200) begin
            echo_len = $urandom_range(1, echo_lim + 2);
        end else if ($urandom_range(0, 15) == 0) begin
            echo_len = $urandom_range(300, 1500);
        end else begin
            echo_len = $urandom_range(1, 300);
        end
        send_tick(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
        // echo level is irrelevant during the trigger
        while (rng_phase == uer_pkg::PH_TLOW || rng_phase == uer_pkg::PH_THIGH) begin
            send_tick(stray_start(), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
        for (n = 0; n < rise_wait && rng_phase == uer_pkg::PH_RISE; n++) begin
            send_tick(stray_start(), 1'b0, 1'b0, '0);
        end
        for (n = 0; n < echo_len && rng_phase != uer_pkg::PH_IDLE; n++) begin
            send_tick(stray_start(), 1'b1, 1'b0, '0);
        end
        if (rng_phase == uer_pkg::PH_ECHO) begin
            send_tick(stray_start(), 1'b0, 1'b0, '0);
        end
    endtask

    // finish any measurement in flight, then wait for every result to arrive
    task automatic settle();
        while (rng_phase != uer_pkg::PH_IDLE) begin
            send_tick(1'b0, rng_phase != uer_pkg::PH_ECHO, 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    // tick source: reset, directed table, then randomised register settings
    initial begin : tick_source
        int p;
        int mark;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_regs(8'd0, 8'd1, 16'd0, 16'd3);
        foreach (DIR_STEPS[k]) begin
            send_tick(DIR_STEPS[k].start, DIR_STEPS[k].echo, DIR_STEPS[k].pinned,
                      DIR_STEPS[k].want);
        end
        settle();

        for (p = 0; p < 8; p++) begin
            // the first settings are the extremes, the rest random
            case (p)
                0: write_regs(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
                1: write_regs(8'd0, 8'd0, 16'd0, 16'd0);
                2: write_regs(8'd1, 8'd1, 16'd1, 16'd1);
                default: write_regs(8'($urandom_range(0, 8)), 8'($urandom_range(0, 16)),
                                    pick_timeout(64), pick_timeout(200));
            endcase
            mark = ticks_sent;
            while (ticks_sent - mark < 180) begin
                if ($urandom_range(0, 3) == 0) begin
                    // noise: random starts and echo levels
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        send_tick(($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                                  1'b0, '0);
                    end
                end else begin
                    run_measurement();
                end
            end
            settle();
        end

        // drain any stray transaction before the verdict
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result sink: random back-pressure, each transaction checked against the oldest reading
    initial begin : result_sink
        uer_pkg::t_result want;
        uer_pkg::t_result got;
        int      stall;
        forever begin
            stall = idle_cycles(1);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got.trig = o_m_tdata[0];
            got.busy = o_m_tdata[1];
            got.done = o_m_tdata[2];
            got.tmo = o_m_tdata[3];
            got.distance = o_m_tdata[14:4];
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
                mismatches++;
            end else begin
                want = pending_readings.pop_front();
                field_check("trigger_level", want.trig, got.trig);
                field_check("busy", want.busy, got.busy);
                field_check("done", want.done, got.done);
                field_check("timed_out", want.tmo, got.tmo);
                field_check("distance_cm", want.distance, got.distance);
            end
        end
    end

    // hard stop well beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ ultrasonic_echo_ranger.f @@
sv/uer_pkg.sv
sv/uer_step.sv
sv/ultrasonic_echo_ranger.sv
sv/uer_checker.sv
tb/ultrasonic_echo_ranger_test.sv
